### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. The enclosing module must
// provide clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/hds_pkg.sv
// ----------------------------------------------------------------------------
// hds_pkg
// Types and constants of the half-scale box downsampler.
// ----------------------------------------------------------------------------
package hds_pkg;

	// Configuration register widths
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CH_CFG_W   = 3;

	// Sample width
	localparam int SAMPLE_W   = 8;

	// Height limit and row counter width
	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_W      = 12;

	// Channel count width, holds up to fifteen
	localparam int CNT_W      = 4;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_CHANNELS = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	// Line store request controls
	typedef struct packed {
		logic wr;
		logic rd;
	} store_ctl_t;

endpackage

### rtl/hds_line_store.sv
// ----------------------------------------------------------------------------
// hds_line_store
// Single-port line store holding the pair averages of the last even row.
// Registered read; contents undefined until written.
// ----------------------------------------------------------------------------
module hds_line_store
	import hds_pkg::*;
#(
	parameter int ADDR_W = 14,
	parameter int DEPTH  = 8192
) (
	input  logic                clk,
	input  store_ctl_t          ctl,
	input  logic [ADDR_W-1:0]   addr,
	input  logic [SAMPLE_W-1:0] wr_data,
	output logic [SAMPLE_W-1:0] rd_data
);

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [SAMPLE_W-1:0] rd_q;

	// Write port
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wr_data;
		end
	end

	// Registered read port; holds while no read is requested
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_q <= mem[addr];
		end
	end

	assign rd_data = rd_q;

endmodule

### rtl/half_scale_box_downsampler.sv
// A result passes through stage 1 and the output register after the request that completes its 2x2 block.
// Throughput: one sample per clock while sample_stall is low; the line store takes one read or one write per
// sample, which sets that figure.
// Reset: positions return to zero and registers to width 4096, height 4096,
// three channels; the line store is not cleared, as every entry is written on the
// even row before the odd row reads it.
// ----------------------------------------------------------------------------
// half_scale_box_downsampler
// 2x2 box average downsampler for interleaved 8-bit raster samples.
// ----------------------------------------------------------------------------
module half_scale_box_downsampler
	import hds_pkg::*;
#(
	parameter int MAX_WIDTH    = 4096,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// input samples
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic [SAMPLE_W-1:0]  sample,
	// results
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [SAMPLE_W-1:0]  scaled_sample,
	output logic                 last_of_image
);

`include "assert_macros.svh"

	// Derived widths
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int CW     = (WW > CFG_W) ? WW : CFG_W;
	localparam int CLW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int PCW    = (MAX_WIDTH > 3) ? $clog2(MAX_WIDTH / 2) : 1;
	localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int ADDR_W = PCW + CHW;
	localparam int DEPTH  = (MAX_WIDTH / 2) * (2 ** CHW);

	// Configuration registers
	logic [CFG_W-1:0]    width_q;
	logic [CFG_W-1:0]    height_q;
	logic [CH_CFG_W-1:0] chans_q;

	// Position counters
	logic [ROW_W-1:0] row_q;
	logic [CLW-1:0]   col_q;
	logic [CHW-1:0]   ch_q;

	// Left sample of each channel's current pair
	logic [SAMPLE_W-1:0] left_q [MAX_CHANNELS];

	// Stage 1 and output register
	logic                s1_valid_q;
	logic [SAMPLE_W-1:0] pair_s1;
	logic                last_s1;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_data_q;
	logic                out_last_q;

	logic [CW-1:0]       w_ext;
	logic [CW-1:0]       w_eff;
	logic [CW-1:0]       used_w;
	logic [CFG_W-1:0]    h_eff;
	logic [CFG_W-1:0]    used_h;
	logic [CNT_W-1:0]    c_ext;
	logic [CNT_W-1:0]    c_eff;
	logic [CW-1:0]       col_ext;
	logic [CFG_W-1:0]    row_ext;
	logic [CNT_W-1:0]    ch_ext;
	logic                cfg_hit;
	logic                accept;
	logic                advance;
	logic                active;
	logic                odd_row;
	logic                pair_done;
	logic                emit;
	logic                last_s0;
	logic                ch_wrap;
	logic                col_wrap;
	logic                row_wrap;
	logic [SAMPLE_W:0]   pair_sum;
	logic [SAMPLE_W-1:0] pair_avg;
	logic [SAMPLE_W:0]   out_sum;
	logic [SAMPLE_W-1:0] store_rd;
	logic [PCW-1:0]      pair_col;
	logic [ADDR_W-1:0]   store_addr;
	store_ctl_t          store_ctl;

	// Clamp the registers to their working ranges
	always_comb begin
		w_ext = CW'(width_q);
		if (w_ext == '0) begin
			w_eff = CW'(1);
		end else if (w_ext > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (height_q == '0) begin
			h_eff = CFG_W'(1);
		end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		c_ext = CNT_W'(chans_q);
		if (c_ext == '0) begin
			c_eff = CNT_W'(1);
		end else if (c_ext > CNT_W'(MAX_CHANNELS)) begin
			c_eff = CNT_W'(MAX_CHANNELS);
		end else begin
			c_eff = c_ext;
		end
		used_w = {w_eff[CW-1:1], 1'b0};
		used_h = {h_eff[CFG_W-1:1], 1'b0};
	end

	// Position decode for the sample on the input
	always_comb begin
		col_ext   = CW'(col_q);
		row_ext   = CFG_W'(row_q);
		ch_ext    = CNT_W'(ch_q);
		active    = (col_ext < used_w) && (row_ext < used_h);
		odd_row   = row_q[0];
		pair_done = active && col_q[0];
		emit      = pair_done && odd_row;
		ch_wrap   = (ch_ext == c_eff - CNT_W'(1));
		col_wrap  = (col_ext == w_eff - CW'(1));
		row_wrap  = (row_ext == h_eff - CFG_W'(1));
		last_s0   = (row_ext == used_h - CFG_W'(1)) && (col_ext == used_w - CW'(1)) &&
			ch_wrap;
		pair_sum  = {1'b0, left_q[ch_q]} + {1'b0, sample};
		pair_avg  = pair_sum[SAMPLE_W:1];
		pair_col  = PCW'(col_q >> 1);
	end

	// Handshake: stage 1 moves on when the output register is free or taken
	assign advance      = !out_valid_q || !result_stall;
	assign sample_stall = s1_valid_q && !advance;
	assign accept       = sample_valid && !sample_stall;
	assign cfg_hit      = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
		cfg_index == REG_CHANNELS);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(4096);
			height_q <= CFG_W'(4096);
			chans_q  <= CH_CFG_W'(3);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH:    width_q  <= cfg_data;
				REG_HEIGHT:   height_q <= cfg_data;
				REG_CHANNELS: chans_q  <= cfg_data[CH_CFG_W-1:0];
				default:      ;
			endcase
		end
	end

	// Raster position counters; a register write starts a new frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			ch_q  <= '0;
		end else if (cfg_hit) begin
			row_q <= '0;
			col_q <= '0;
			ch_q  <= '0;
		end else if (accept) begin
			if (ch_wrap) begin
				ch_q <= '0;
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + CLW'(1);
				end
			end else begin
				ch_q <= ch_q + CHW'(1);
			end
		end
	end

	// Left sample of a pair
	always_ff @(posedge clk) begin
		if (accept && active && !col_q[0]) begin
			left_q[ch_q] <= sample;
		end
	end

	// Line store: write pair averages on even rows, read them back on odd rows
	assign store_addr   = {pair_col, ch_q};
	assign store_ctl.wr = accept && pair_done && !odd_row;
	assign store_ctl.rd = accept && emit;

	hds_line_store #(
		.ADDR_W (ADDR_W),
		.DEPTH  (DEPTH)
	) u_line_store (
		.clk     (clk),
		.ctl     (store_ctl),
		.addr    (store_addr),
		.wr_data (pair_avg),
		.rd_data (store_rd)
	);

	// Stage 1: pair average waits for the stored value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= emit;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			pair_s1 <= pair_avg;
			last_s1 <= last_s0;
		end
	end

	// Output register: vertical average
	assign out_sum = {1'b0, store_rd} + {1'b0, pair_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q) begin
			out_data_q <= out_sum[SAMPLE_W:1];
			out_last_q <= last_s1;
		end
	end

	assign result_valid  = out_valid_q;
	assign scaled_sample = out_data_q;
	assign last_of_image = out_last_q;

	// Checks; the frame must restart after the last block when it sits in the last column and row
	`ASSERT_SAME(a_pos_range, 1'b1, (col_ext < w_eff) && (ch_ext < c_eff), "position out of frame")
	`ASSERT_NEXT(a_frame_wrap, accept && last_s0 && col_wrap && row_wrap && !cfg_hit, (row_q == '0) && (col_q == '0) && (ch_q == '0), "frame did not restart")
	`ASSERT_SAME(a_store_excl, 1'b1, !(store_ctl.wr && store_ctl.rd), "line store read and write together")

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the half-scale box downsampler. Raster samples
// are streamed through small, odd-sized and extreme frame geometries, with
// random request gaps and result back-pressure. A scoreboard follows the
// frame position, the per-channel pair holds and the even-row line store.
// From these it predicts every 2x2 average and its end-of-image flag, and
// checks each result in order.
// ----------------------------------------------------------------------------
module tb;
	import hds_pkg::*;

	localparam int LINE_WIDTH_MAX = 4096;
	localparam int CHANNEL_MAX    = 4;
	localparam int LINE_SLOTS     = LINE_WIDTH_MAX / 2 * CHANNEL_MAX;
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int SETTLE_CYCLES  = 8;

	// one predicted output sample
	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                last;
	} average_t;

	// Tracks frame position and line store; predicts each 2x2 average
	class downscale_scoreboard;
		bit [CFG_W-1:0]    width_reg;
		bit [CFG_W-1:0]    height_reg;
		bit [CH_CFG_W-1:0] chan_reg;
		int                row;
		int                col;
		int                chan;
		bit [SAMPLE_W-1:0] left_hold [CHANNEL_MAX];
		bit [SAMPLE_W-1:0] pair_line [LINE_SLOTS];
		average_t          pending_averages [$];
		int                errors;

		function new();
			width_reg  = 13'd4096;
			height_reg = 13'd4096;
			chan_reg   = 3'd3;
			row        = 0;
			col        = 0;
			chan       = 0;
			errors     = 0;
		endfunction

		// zero acts as one, anything above the top acts as the top
		function int clamp(int v, int hi);
			if (v < 1)
				return 1;
			if (v > hi)
				return hi;
			return v;
		endfunction

		// any write to a real register restarts the frame
		function void write_reg(reg_idx_t idx, bit [CFG_W-1:0] val);
			case (idx)
				REG_WIDTH:    width_reg  = val;
				REG_HEIGHT:   height_reg = val;
				REG_CHANNELS: chan_reg   = val[CH_CFG_W-1:0];
				default:      return;
			endcase
			row  = 0;
			col  = 0;
			chan = 0;
		endfunction

		function void take_sample(bit [SAMPLE_W-1:0] s);
			int       w;
			int       h;
			int       c;
			int       used_w;
			int       used_h;
			int       slot;
			int       pair;
			int       avg;
			average_t item;
			w      = clamp(width_reg, LINE_WIDTH_MAX);
			h      = clamp(height_reg, MAX_HEIGHT);
			c      = clamp(chan_reg, CHANNEL_MAX);
			used_w = w / 2 * 2;
			used_h = h / 2 * 2;
			if (col >= w || row >= h || chan >= c) begin
				row  = 0;
				col  = 0;
				chan = 0;
			end
			// trailing odd column and row are consumed silently
			if (col < used_w && row < used_h) begin
				if (col % 2 == 0) begin
					left_hold[chan] = s;
				end else begin
					pair = (int'(left_hold[chan]) + int'(s)) >> 1;
					slot = col / 2 * CHANNEL_MAX + chan;
					if (row % 2 == 0) begin
						pair_line[slot] = 8'(pair);
					end else begin
						avg        = (int'(pair_line[slot]) + pair) >> 1;
						item.value = 8'(avg);
						item.last  = (row == used_h - 1) && (col == used_w - 1) &&
							(chan == c - 1);
						pending_averages.push_back(item);
					end
				end
			end
			// advance channel, column, row with wrap at end of frame
			chan++;
			if (chan >= c) begin
				chan = 0;
				col++;
				if (col >= w) begin
					col = 0;
					row++;
					if (row >= h)
						row = 0;
				end
			end
		endfunction

		function void compare_average(logic [SAMPLE_W-1:0] got, logic got_last);
			average_t want;
			if (pending_averages.size() == 0) begin
				$error("unexpected result: scaled_sample %0d, last_of_image %0b", got, got_last);
				errors++;
				return;
			end
			want = pending_averages.pop_front();
			if (got !== want.value) begin
				$error("scaled_sample: expected %0d, got %0d", want.value, got);
				errors++;
			end
			if (got_last !== want.last) begin
				$error("last_of_image: expected %0b, got %0b", want.last, got_last);
				errors++;
			end
		endfunction

		function int pending();
			return pending_averages.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 sample_valid;
	logic                 sample_stall;
	logic [SAMPLE_W-1:0]  sample;
	logic                 result_valid;
	logic                 result_stall;
	logic [SAMPLE_W-1:0]  scaled_sample;
	logic                 last_of_image;

	downscale_scoreboard sb;
	int                  send_idle_pct;
	int                  recv_idle_pct;
	int                  sent;
	int                  cycles;

	half_scale_box_downsampler #(
		.MAX_WIDTH    (LINE_WIDTH_MAX),
		.MAX_CHANNELS (CHANNEL_MAX)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.scaled_sample (scaled_sample),
		.last_of_image (last_of_image)
	);

	// 2 ns clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// result side: check accepted results, then pick next cycle's stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.compare_average(scaled_sample, last_of_image);
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one sample request, with random gaps ahead of it
	task automatic send_sample(logic [SAMPLE_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (sample_stall);
		sb.take_sample(s);
		sent++;
	endtask

	// stop requests and let every expected result arrive
	task automatic drain();
		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic configure(int w, int h, int c);
		write_reg(REG_WIDTH, CFG_W'(w));
		write_reg(REG_HEIGHT, CFG_W'(h));
		write_reg(REG_CHANNELS, CFG_W'(c));
		cfg_we <= 1'b0;
	endtask

	// program a geometry and stream random samples; optional mid-way hold-off
	task automatic stream(int w, int h, int c, int count, bit hold_off);
		int i;
		configure(w, h, c);
		for (i = 0; i < count; i++) begin
			if (hold_off && i == count / 2)
				drain();
			send_sample(8'($urandom_range(255)));
		end
		drain();
	endtask

	// mostly whole frames of small random geometry, some cut short
	task automatic random_phases(int quota);
		int w;
		int h;
		int c;
		int frame;
		int count;
		int phase;
		int start;
		start = sent;
		phase = 0;
		while (sent - start < quota) begin
			w     = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(8, 2);
			h     = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(6, 2);
			c     = $urandom_range(7);
			frame = sb.clamp(w, LINE_WIDTH_MAX) * sb.clamp(h, MAX_HEIGHT) *
				sb.clamp(c, CHANNEL_MAX);
			if ($urandom_range(9) == 0)
				count = $urandom_range(frame, 1);
			else
				count = frame * $urandom_range(2, 1);
			stream(w, h, c, count, phase % 3 == 0);
			phase++;
		end
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_WIDTH;
		cfg_data      = '0;
		sample_valid  = 1'b0;
		sample        = '0;
		result_stall  = 1'b0;
		send_idle_pct = 35;
		recv_idle_pct = 87;
		sent          = 0;
		cycles        = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2x2 single channel: saturated block, then truncation in both pair averages
		configure(2, 2, 1);
		repeat (4) send_sample(8'hFF);
		send_sample(8'd255);
		send_sample(8'd254);
		send_sample(8'd1);
		send_sample(8'd0);
		drain();

		// zero registers act as one: 1x1 frames, never a result
		configure(0, 0, 0);
		send_sample(8'd0);
		send_sample(8'hFF);
		drain();

		// odd width drops the last column; unused index must not restart the frame
		configure(3, 2, 2);
		repeat (6) send_sample(8'($urandom_range(255)));
		drain();
		write_reg(REG_NONE, 13'h1FFF);
		cfg_we <= 1'b0;
		repeat (6) send_sample(8'($urandom_range(255)));
		drain();

		random_phases(200);

		// sender idles more than receiver; tall frame, height and channels clamped
		send_idle_pct = 87;
		recv_idle_pct = 35;
		stream(2, 8191, 7, 48, 1'b1);
		random_phases(200);

		// no idling; wide frame with width clamped, first row only
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stream(8191, 2, 1, 16, 1'b0);
		random_phases(200);

		drain();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/hds_pkg.sv
rtl/hds_line_store.sv
rtl/half_scale_box_downsampler.sv
sim/tb.sv
